// File: hw/rtl/lba_pkg.sv
// Shared constants, codes and types of the linked block allocator.
package lba_pkg;

  // Pool and file table sizes
  localparam int BLOCKS  = 64;
  localparam int FILES   = 16;
  localparam int BLOCK_W = $clog2(BLOCKS);
  localparam int CNT_W   = BLOCK_W + 1;
  localparam int FILE_W  = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int FCNT_W  = FILE_W + 1;

  // Fixed port widths
  localparam int SIZE_W     = 7;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int BLKO_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Probe LFSR
  localparam int                LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  // Next-block table entries
  localparam int                LINK_W    = 8;
  localparam logic [LINK_W-1:0] LINK_FREE = 8'hFF;
  localparam logic [LINK_W-1:0] LINK_END  = 8'hFE;

  // Item functions
  localparam logic FUNC_CREATE = 1'b0;
  localparam logic FUNC_WALK   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FILE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd1;

  typedef struct packed {
    logic start;
    logic load;
  } probe_ctl_t;

  typedef struct packed {
    logic                en;
    logic [BLOCK_W-1:0]  addr;
    logic [LINK_W-1:0]   data;
  } link_wr_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLKO_W-1:0]   block;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } result_t;

endpackage

// File: hw/rtl/lba_link_mem.sv
// Next-block table: synchronous memory with per-entry valid bits.
module lba_link_mem import lba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  link_wr_t           wr,
  input  logic [BLOCK_W-1:0] rd_addr,
  output logic [LINK_W-1:0]  rd_data
);

  logic [LINK_W-1:0] mem [BLOCKS];
  logic [BLOCKS-1:0] valid;
  logic [LINK_W-1:0] data_q;
  logic              valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    data_q <= mem[rd_addr];
  end

  // An entry never written since the last clear reads as free.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? data_q : LINK_FREE;

endmodule

// File: hw/rtl/lba_probe.sv
// Probe source: Galois LFSR and an iterative modulo unit over the pool size.
module lba_probe import lba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  probe_ctl_t         ctl,
  input  logic [LFSR_W-1:0]  seed,
  input  logic [CNT_W-1:0]   pool_n,
  output logic               done,
  output logic [BLOCK_W-1:0] idx
);

  localparam int DIGIT_W = 4;
  localparam int STEPS   = LFSR_W / DIGIT_W;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [LFSR_W-1:0]  lfsr;
  logic [LFSR_W-1:0]  lfsr_next;
  logic [LFSR_W-1:0]  sh;
  logic [BLOCK_W-1:0] rem;
  logic [BLOCK_W-1:0] rem_next;
  logic [STEP_W-1:0]  step;
  logic               busy;

  // One restoring step: the partial remainder stays below twice the divisor.
  function automatic logic [BLOCK_W-1:0] mod_step(input logic [BLOCK_W-1:0] r,
                                                  input logic b,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] t;
    t = {r, b};
    if (t >= n) begin
      t = t - n;
    end
    return t[BLOCK_W-1:0];
  endfunction

  assign lfsr_next = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_MASK : '0);

  always_comb begin
    rem_next = rem;
    for (int j = 0; j < DIGIT_W; j++) begin
      rem_next = mod_step(rem_next, sh[LFSR_W-1-j], pool_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_W'(1);
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.load) begin
        lfsr <= (seed == '0) ? LFSR_W'(1) : seed;
      end else if (ctl.start) begin
        lfsr <= lfsr_next;
        sh   <= lfsr_next;
        rem  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        sh   <= sh << DIGIT_W;
        rem  <= rem_next;
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign idx = rem;

  assert property (@(posedge clk) disable iff (rst) done |-> (CNT_W'(idx) < pool_n))
    else $error("probe index outside the pool");
  assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("probe started while a modulo is in flight");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("probe done while still busy");

endmodule

// File: hw/rtl/linked_block_allocator_top.sv
// Top level of the linked block allocator: control sequencer, file table, result register.
//
// Items enter on item_valid/item_stall with func, file_size and file_slot; a
// transaction completes at an edge with item_valid high and item_stall low.
// Results leave on result_valid/result_stall with status, block, slot_out, last.
// A create gives one result; a walk gives one result per chained block, last
// marking the final one. Registers are written on cfg_valid/cfg_ready by index:
// 0 total_blocks (pool rebuilt: all free, no files), 1 probe_seed (LFSR reload).
// Flow control: item_stall is high from acceptance until the item's final result
// sits in the output register, and while a register write is offered.
// Each create probe runs a 16-bit LFSR value through a 4-bit-per-cycle modulo
// unit and one read of the next-block memory; a probe that hits a taken block
// is repeated. A walk runs through one memory read, one decode and one handoff
// to the output register for each listed block.
// A stalled receiver holds the output register; the sequencer waits before
// handing over the next result, and a new item is taken while the final one
// still waits. Reset frees the whole pool at once through valid bits, sets a
// pool of 64 blocks with no files and loads the LFSR with 1.
module linked_block_allocator_top import lba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  func,
  input  logic [SIZE_W-1:0]     file_size,
  input  logic [SLOT_W-1:0]     file_slot,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [BLKO_W-1:0]     block,
  output logic [SLOT_W-1:0]     slot_out,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_CMP_W = SLOT_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_ADV   = 3'd4;
  localparam logic [2:0] S_WREAD = 3'd5;
  localparam logic [2:0] S_WCHK  = 3'd6;
  localparam logic [2:0] S_SEND  = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CNT_W-1:0]   pool_n;
  logic [CNT_W-1:0]   free_count;
  logic [FCNT_W-1:0]  file_count;
  logic [CNT_W-1:0]   size_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   placed;
  logic [BLOCK_W-1:0] cur_b;
  logic [BLOCK_W-1:0] prev_b;
  logic [BLOCK_W-1:0] first_b;
  logic [BLOCK_W-1:0] walk_k;
  result_t            res;
  result_t            out_res;

  // Start block of each file; only slots below file_count are ever used.
  // The file length is never read back, so it is not kept.
  logic [BLOCK_W-1:0] file_start [FILES];

  logic               item_acc;
  logic               cfg_acc;
  logic               out_free;
  logic               table_full;
  logic               no_space;
  logic               no_file;
  logic               link_free;
  logic               walk_end;
  logic               create_done;
  probe_ctl_t         probe_ctl;
  logic               probe_done;
  logic [BLOCK_W-1:0] probe_idx;
  link_wr_t           link_wr;
  logic [BLOCK_W-1:0] rd_addr;
  logic [LINK_W-1:0]  link_q;
  logic               pool_clear;

  // Clamp a requested pool size into 1..BLOCKS.
  function automatic logic [CNT_W-1:0] pool_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end
    if (v > SIZE_W'(BLOCKS)) begin
      return CNT_W'(BLOCKS);
    end
    return v[CNT_W-1:0];
  endfunction

  // Hold items off while a register write is offered, so the two never meet.
  assign item_stall = (state != S_IDLE) || cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !result_valid || !result_stall;

  // Checks made before any table change
  assign table_full = (file_count >= FCNT_W'(FILES));
  assign no_space   = (file_size == '0) || (file_size > SIZE_W'(free_count));
  assign no_file    = (SLOT_CMP_W'(file_slot) >= SLOT_CMP_W'(file_count));

  assign link_free   = (link_q == LINK_FREE);
  assign walk_end    = (link_q >= LINK_W'(BLOCKS)) || (walk_k == BLOCK_W'(BLOCKS - 1));
  assign create_done = (placed == size_q);

  assign pool_clear = cfg_acc && (cfg_index == CFG_TOTAL);

  always_comb begin
    probe_ctl.load  = cfg_acc && (cfg_index == CFG_SEED);
    probe_ctl.start = 1'b0;
    link_wr.en      = 1'b0;
    link_wr.addr    = cur_b;
    link_wr.data    = LINK_END;
    state_next      = state;
    case (state)
      S_IDLE: begin
        if (item_acc) begin
          if (func == FUNC_CREATE) begin
            if (table_full || no_space) begin
              state_next = S_SEND;
            end else begin
              probe_ctl.start = 1'b1;
              state_next      = S_PROBE;
            end
          end else begin
            state_next = no_file ? S_SEND : S_WREAD;
          end
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (link_free) begin
          // Mark the block taken; it is relinked later if another follows.
          link_wr.en = 1'b1;
          state_next = (placed == '0) ? S_ADV : S_LINK;
        end else begin
          probe_ctl.start = 1'b1;
          state_next      = S_PROBE;
        end
      end
      S_LINK: begin
        link_wr.en   = 1'b1;
        link_wr.addr = prev_b;
        link_wr.data = LINK_W'(cur_b);
        state_next   = S_ADV;
      end
      S_ADV: begin
        if (create_done) begin
          state_next = S_SEND;
        end else begin
          probe_ctl.start = 1'b1;
          state_next      = S_PROBE;
        end
      end
      S_WREAD: begin
        state_next = S_WCHK;
      end
      S_WCHK: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          state_next = res.last ? S_IDLE : S_WREAD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Present the probed index straight from the modulo unit; otherwise the current block.
  assign rd_addr = (state == S_PROBE) ? probe_idx : cur_b;

  lba_probe u_probe (
    .clk    (clk),
    .rst    (rst),
    .ctl    (probe_ctl),
    .seed   (cfg_data[LFSR_W-1:0]),
    .pool_n (pool_n),
    .done   (probe_done),
    .idx    (probe_idx)
  );

  // Accesses are strictly sequenced: every write lands before the next read of
  // the table, so no forwarding is needed.
  lba_link_mem u_link_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (pool_clear),
    .wr      (link_wr),
    .rd_addr (rd_addr),
    .rd_data (link_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pool_n       <= CNT_W'(BLOCKS);
      free_count   <= CNT_W'(BLOCKS);
      file_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Drop the result once taken; load the next one when the register is free.
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if ((state == S_SEND) && out_free) begin
        result_valid <= 1'b1;
        out_res      <= res;
      end

      if (pool_clear) begin
        pool_n     <= pool_size(cfg_data[SIZE_W-1:0]);
        free_count <= pool_size(cfg_data[SIZE_W-1:0]);
        file_count <= '0;
      end

      case (state)
        S_IDLE: begin
          if (item_acc) begin
            slot_q <= file_slot;
            size_q <= CNT_W'(file_size);
            placed <= '0;
            walk_k <= '0;
            cur_b  <= file_start[file_slot[FILE_W-1:0]];
            if (func == FUNC_CREATE) begin
              res <= '{status: table_full ? ST_TABLE_FULL : ST_NO_SPACE,
                       block: '0, slot: '0, last: 1'b1};
            end else begin
              res <= '{status: ST_NO_FILE, block: '0, slot: file_slot, last: 1'b1};
            end
          end
        end
        S_PROBE: begin
          if (probe_done) begin
            cur_b <= probe_idx;
          end
        end
        S_CHECK: begin
          if (link_free) begin
            placed <= placed + CNT_W'(1);
            if (placed == '0) begin
              first_b <= cur_b;
            end
          end
        end
        S_ADV: begin
          prev_b <= cur_b;
          if (create_done) begin
            file_count <= file_count + FCNT_W'(1);
            free_count <= free_count - placed;
            res <= '{status: ST_OK, block: BLKO_W'(first_b),
                     slot: SLOT_W'(file_count), last: 1'b1};
          end
        end
        S_WCHK: begin
          res    <= '{status: ST_OK, block: BLKO_W'(cur_b), slot: slot_q, last: walk_end};
          cur_b  <= link_q[BLOCK_W-1:0];
          walk_k <= walk_k + BLOCK_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_ADV) && create_done) begin
      file_start[file_count[FILE_W-1:0]] <= first_b;
    end
  end

  assign status   = out_res.status;
  assign block    = out_res.block;
  assign slot_out = out_res.slot;
  assign last     = out_res.last;

  assert property (@(posedge clk) disable iff (rst) free_count <= pool_n)
    else $error("free count exceeds pool size");
  assert property (@(posedge clk) disable iff (rst) file_count <= FCNT_W'(FILES))
    else $error("file count exceeds file table");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_CHECK) |-> (CNT_W'(cur_b) < pool_n))
    else $error("probed block outside the pool");
  assert property (@(posedge clk) disable iff (rst)
                   ((state == S_SEND) && out_free) |=> result_valid)
    else $error("result handed over but not presented");

endmodule

// File: tb/sv/linked_block_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the linked block allocator top level with its own allocation predictor.
module linked_block_allocator_top_tb;
  import lba_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_PCT    = 31;
  localparam int HOLD_AT     = 35;   // accepted transactions before the long output hold
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 190;  // directed and random items; random phases stop once reached

  typedef struct {
    logic              f;
    logic [SIZE_W-1:0] size;
    logic [SLOT_W-1:0] slot;
  } file_req_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  logic                  func         = FUNC_CREATE;
  logic [SIZE_W-1:0]     file_size    = '0;
  logic [SLOT_W-1:0]     file_slot    = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [BLKO_W-1:0]     block;
  logic [SLOT_W-1:0]     slot_out;
  logic                  last;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  linked_block_allocator_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .file_size    (file_size),
    .file_slot    (file_slot),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .block        (block),
    .slot_out     (slot_out),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the pool, the file table and the probe
  // LFSR. It advances once per accepted transaction and per register write.
  // ---------------------------------------------------------------------------
  logic [LINK_W-1:0]  chain_link [BLOCKS];
  logic [BLOCK_W-1:0] file_head  [FILES];
  int unsigned        files_used;
  int unsigned        blocks_free;
  logic [LFSR_W-1:0]  probe_reg;
  logic [SIZE_W-1:0]  pool_cfg;

  file_req_t   req_q[$];      // items waiting for the driver
  result_t     due_q[$];      // results the block still owes, oldest first
  int unsigned errors         = 0;
  int unsigned accepted_items = 0;
  int unsigned cycles         = 0;
  int unsigned queued         = 0;
  logic        item_taken     = 1'b0;
  logic        settled        = 1'b0;
  logic        calm           = 1'b0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  // Block and file counts that the queued stimulus will leave behind; used
  // only to shape the stimulus toward well-formed sequences.
  int unsigned plan_files;
  int unsigned plan_free;

  // Effective pool size: zero reads as one, anything above the pool as the pool.
  function automatic int unsigned pool_blocks();
    if (pool_cfg == 0) return 1;
    if (pool_cfg > BLOCKS) return BLOCKS;
    return pool_cfg;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < BLOCKS; i++) chain_link[i] = LINK_FREE;
    files_used  = 0;
    blocks_free = pool_blocks();
  endfunction

  // Step the Galois LFSR once per probe until it lands on a free block.
  function automatic int unsigned probe_free_block();
    int unsigned n;
    int unsigned b;
    logic        lsb;
    n = pool_blocks();
    b = 0;
    for (int t = 0; t < 65536; t++) begin
      lsb       = probe_reg[0];
      probe_reg = probe_reg >> 1;
      if (lsb) probe_reg ^= LFSR_MASK;
      b = probe_reg % n;
      if (chain_link[b] == LINK_FREE) break;
    end
    return b;
  endfunction

  function automatic void owe(logic [STATUS_W-1:0] st, int unsigned blk,
                              int unsigned sl, logic fin);
    result_t r;
    r.status = st;
    r.block  = blk[BLKO_W-1:0];
    r.slot   = sl[SLOT_W-1:0];
    r.last   = fin;
    due_q.push_back(r);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_TOTAL) begin
      pool_cfg = data[SIZE_W-1:0];
      clear_pool();
    end else if (idx == CFG_SEED) begin
      probe_reg = (data == 0) ? LFSR_W'(1) : data;
    end
  endfunction

  // Work out every result one accepted transaction causes.
  function automatic void allocator_step(logic f, logic [SIZE_W-1:0] sz, logic [SLOT_W-1:0] sl);
    int unsigned b;
    int unsigned prev;
    int unsigned first;
    int unsigned k;
    logic        fin;
    prev  = 0;
    first = 0;
    if (f == FUNC_CREATE) begin
      if (files_used >= FILES) begin
        owe(ST_TABLE_FULL, 0, 0, 1'b1);
      end else if (sz == 0 || sz > blocks_free) begin
        owe(ST_NO_SPACE, 0, 0, 1'b1);
      end else begin
        for (int i = 0; i < sz; i++) begin
          b = probe_free_block();
          if (i == 0) first = b;
          else chain_link[prev] = LINK_W'(b);
          chain_link[b] = LINK_END;  // taken; relinked unless it stays last
          prev = b;
        end
        file_head[files_used] = BLOCK_W'(first);
        owe(ST_OK, first, files_used, 1'b1);
        files_used++;
        blocks_free -= sz;
      end
    end else if (sl >= files_used) begin
      owe(ST_NO_FILE, 0, sl, 1'b1);
    end else begin
      // Follow links; stop at the end mark, a bad link or a full pool's worth.
      b = file_head[sl];
      k = 0;
      do begin
        fin = (chain_link[b] >= BLOCKS) || (k + 1 >= BLOCKS);
        owe(ST_OK, b, sl, fin);
        k++;
        b = chain_link[b];
      end while (!fin);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers: queue one item and track the counts it will leave.
  // ---------------------------------------------------------------------------
  function automatic void add_create(int unsigned sz);
    file_req_t req;
    req.f    = FUNC_CREATE;
    req.size = SIZE_W'(sz);
    req.slot = SLOT_W'($urandom_range(FILES - 1));  // ignored on create
    req_q.push_back(req);
    queued++;
    if (plan_files < FILES && sz != 0 && sz <= plan_free) begin
      plan_files++;
      plan_free -= sz;
    end
  endfunction

  function automatic void add_walk(int unsigned sl);
    file_req_t req;
    req.f    = FUNC_WALK;
    req.size = SIZE_W'($urandom_range(127));  // ignored on walk
    req.slot = SLOT_W'(sl);
    req_q.push_back(req);
    queued++;
  endfunction

  // Mostly valid creates and walks of existing files, with some noise:
  // size zero, oversize requests, walks of missing files.
  function automatic void add_random();
    int unsigned r;
    int unsigned cap;
    r   = $urandom_range(99);
    cap = (plan_free < 6) ? plan_free : 6;
    if (r < 12) begin
      case ($urandom_range(3))
        0: add_create(0);
        1: add_create(plan_free < BLOCKS ? $urandom_range(BLOCKS, plan_free + 1) : 0);
        2: add_walk(plan_files < FILES ? $urandom_range(FILES - 1, plan_files)
                                       : $urandom_range(FILES - 1));
        default: add_create($urandom_range(BLOCKS));
      endcase
    end else if (plan_files == 0 || (r < 55 && plan_files < FILES && plan_free > 0)) begin
      // Mostly small files; now and then one that may take the rest of the pool.
      add_create(($urandom_range(9) == 0) ? $urandom_range(plan_free, 1)
                                          : $urandom_range(cap, 1));
    end else begin
      add_walk($urandom_range(plan_files - 1));
    end
  endfunction

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOTAL) begin
      plan_files = 0;
      plan_free  = data;
    end
  endtask

  // Wait until every queued item is accepted and every result has arrived,
  // then let the block come to rest.
  task automatic settle();
    do @(negedge clk); while (!settled);
    repeat (10) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: present the next queued item at the falling edge, hold the
  // payload until the transaction completes, idle at random between items.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    file_req_t req;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        req = req_q.pop_front();
        item_valid <= 1'b1;
        func       <= req.f;
        file_size  <= req.size;
        file_slot  <= req.slot;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random, and once hold off for a long stretch
  // while the driver keeps offering, so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge. Check results before
  // predicting, so a result can never match an item accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** linked_block_allocator_top: FAILED **");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (result_valid && !result_stall) begin
        if (due_q.size() == 0) begin
          report_mismatch("unexpected result, block", block, -1);
        end else begin
          want = due_q.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (block !== want.block) report_mismatch("block", block, want.block);
          if (slot_out !== want.slot) report_mismatch("slot_out", slot_out, want.slot);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (item_valid && !item_stall) begin
        allocator_step(func, file_size, file_slot);
        accepted_items++;
      end
      item_taken <= item_valid && !item_stall;
      // An item accepted at this edge leaves results due, so it keeps this low.
      settled <= (req_q.size() == 0) && (due_q.size() == 0) && !item_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned n;
    pool_cfg  = SIZE_W'(BLOCKS);
    probe_reg = LFSR_W'(1);
    clear_pool();
    plan_files = 0;
    plan_free  = BLOCKS;
    phase      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default pool: walk with no files, size zero, the whole pool as one
    // chain, a walk of that full-length chain, then no room left.
    add_walk(0);
    add_create(0);
    add_create(BLOCKS);
    add_walk(0);
    add_create(1);
    add_walk(FILES - 1);
    settle();

    // Smallest pool and the all-ones seed: oversize, the one block, its walk.
    write_reg(CFG_TOTAL, CFG_DATA_W'(1));
    write_reg(CFG_SEED, 16'hFFFF);
    add_create(2);
    add_create(1);
    add_walk(0);
    settle();

    // Fill the file table; a full table wins over size zero.
    write_reg(CFG_TOTAL, CFG_DATA_W'(20));
    write_reg(CFG_SEED, CFG_DATA_W'(1));
    repeat (FILES) add_create(1);
    add_create(0);
    add_walk(FILES - 1);
    settle();

    // Random phases, each on a freshly set up pool; one runs with no idling.
    while (queued < ITEM_TARGET) begin
      phase++;
      write_reg(CFG_TOTAL, CFG_DATA_W'((phase % 3 == 0) ? BLOCKS : $urandom_range(40, 2)));
      if ($urandom_range(1) == 1) write_reg(CFG_SEED, CFG_DATA_W'($urandom_range(65535, 1)));
      calm <= (phase == 2);
      n = $urandom_range(32, 20);
      repeat (n) add_random();
      settle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) $display("** linked_block_allocator_top: PASSED **");
    else $display("** linked_block_allocator_top: FAILED **");
    $finish;
  end

endmodule
